FILE: design/htc_pkg.sv
// Shared widths, reset values, register codes and the drive level table
// of the heater temperature controller. No dependencies.

package htc_pkg;

    localparam int SAMPLE_W       = 16;  // raw sample and average
    localparam int CFG_W          = 15;  // configuration register width
    localparam int LEVEL_W        = 8;   // triac drive level
    localparam int WINDOW_LEN_DEF = 50;  // moving average window

    localparam logic [CFG_W-1:0] TARGET_RST     = 15'd0;
    localparam logic [CFG_W-1:0] OVER_LIMIT_RST = 15'd6000;
    localparam logic [CFG_W-1:0] ENTER_RST      = 15'd70;
    localparam logic [CFG_W-1:0] LEAVE_RST      = 15'd50;

    // Proportional drive: level = error * LEVEL_MAX / LEVEL_SPAN, clamped.
    localparam int LEVEL_MAX   = 255;
    localparam int LEVEL_SPAN  = 50;
    localparam int LEVEL_IDX_W = $clog2(LEVEL_SPAN);
    localparam int LEVEL_DEPTH = 2 ** LEVEL_IDX_W;

    typedef enum logic [1:0] {
        CFG_TARGET     = 2'd0,
        CFG_OVER_LIMIT = 2'd1,
        CFG_ENTER      = 2'd2,
        CFG_LEAVE      = 2'd3
    } cfg_index_t;

    typedef logic [LEVEL_W-1:0] level_lut_t [0:LEVEL_DEPTH-1];

    // Evaluated at elaboration only; entries at or past the span clamp.
    function automatic level_lut_t build_level_lut();
        level_lut_t lut;
        for (int i = 0; i < LEVEL_DEPTH; i++) begin
            if (i >= LEVEL_SPAN) begin
                lut[i] = LEVEL_W'(LEVEL_MAX);
            end else begin
                lut[i] = LEVEL_W'((i * LEVEL_MAX) / LEVEL_SPAN);
            end
        end
        return lut;
    endfunction

    localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

FILE: design/htc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.

module htc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/htc_avg_div.sv
// Divides the ring sum by the window length, truncating toward zero, with a
// reciprocal multiply. Depends on htc_pkg.

module htc_avg_div #(
    parameter int WINDOW_LEN = htc_pkg::WINDOW_LEN_DEF
) (
    input  logic signed [htc_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0] sum_i,
    output logic signed [htc_pkg::SAMPLE_W-1:0]                    avg_o
);

    import htc_pkg::*;

    localparam int MAG_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int SHIFT  = MAG_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W = MAG_W + RECIP_W;
    // Rounded-up reciprocal; exact floor quotient for every magnitude below 2**MAG_W.
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SAMPLE_W-1:0] quot;

    assign neg  = sum_i[MAG_W-1];
    assign mag  = neg ? $unsigned(-sum_i) : $unsigned(sum_i);
    assign prod = PROD_W'(mag) * PROD_W'(RECIP);
    assign quot = prod[SHIFT +: SAMPLE_W];
    assign avg_o = neg ? $signed(-quot) : $signed(quot);

endmodule

FILE: design/heater_temperature_controller_top.sv
// Heater temperature controller: moving average over a sample ring, sticky
// over-temperature trip and preheat / proportional drive with hysteresis.
// Depends on htc_pkg, htc_ram and htc_avg_div.
//
//   channel   direction  ports                                   carries
//   s_        in         s_valid s_ready s_raw_sample s_cooking  one control tick word
//   m_        out        m_valid m_ready m_triac_level ...       one result word per tick
//   cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  one register write word
//
// The block takes one word every cycle unless results stall. A tick word is
// captured in an input register and its result is computed in a single pass
// into the state and result registers, so m_valid rises when the word leaves
// the input register unless an older result is stalled. The result registers
// are the controller's hold state itself; while a result stalls on m_ready,
// one more tick word waits in the input register and s_ready drops only when
// both are full. Reset is synchronous and active low; the sample ring needs no
// clearing pass because each entry carries a valid bit and reads as zero until
// first written. Configuration writes are always accepted (cfg_ready is tied high).

module heater_temperature_controller_top #(
    parameter int WINDOW_LEN = htc_pkg::WINDOW_LEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [htc_pkg::SAMPLE_W-1:0]   s_raw_sample,
    input  logic                                  s_cooking,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [htc_pkg::LEVEL_W-1:0]           m_triac_level,
    output logic                                  m_preheat_on,
    output logic                                  m_master_on,
    output logic signed [htc_pkg::SAMPLE_W-1:0]   m_average_temperature,
    output logic                                  m_over_temp_error,
    output logic                                  m_preheating,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  htc_pkg::cfg_index_t                   cfg_index,
    input  logic [htc_pkg::CFG_W-1:0]             cfg_data
);

    import htc_pkg::*;

    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int DIFF_W = SAMPLE_W + 2;

    // Configuration registers.
    logic [CFG_W-1:0] target_reg, over_limit_reg, enter_reg, leave_reg;

    // Input register.
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       cooking_reg;

    // Controller state; the hold registers double as the result payload.
    logic [POS_W-1:0]           wp_reg, wp_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [WINDOW_LEN-1:0]      ring_valid_reg;
    logic                       mode_reg, mode_next;
    logic                       error_reg, error_next;
    logic [LEVEL_W-1:0]         triac_reg, triac_next;
    logic                       preheat_reg, preheat_next;
    logic                       master_reg, master_next;
    logic signed [SAMPLE_W-1:0] avg_out_reg;
    logic                       out_valid_reg;

    // Ring read path: the next write position is always being read, and a
    // write that lands on that same entry is forwarded.
    logic [SAMPLE_W-1:0]        ram_rd_data;
    logic                       bypass_reg;
    logic signed [SAMPLE_W-1:0] bypass_data_reg;
    logic signed [SAMPLE_W-1:0] old_sample;

    logic                       advance;
    logic                       ring_wr;
    logic signed [SUM_W-1:0]    sum_upd;
    logic signed [SUM_W-1:0]    div_in;
    logic signed [SAMPLE_W-1:0] avg;
    logic                       over_temp;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   enter_ext, leave_ext;
    logic [LEVEL_W-1:0]         level;

    // A tick moves to the result side when the result slot is free or freeing.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign ring_wr = advance && cooking_reg;
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign wp_next = !ring_wr ? wp_reg :
                     (wp_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : wp_reg + POS_W'(1);

    htc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_addr (wp_next),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        if (!ring_valid_reg[wp_reg]) begin
            old_sample = '0;
        end else if (bypass_reg) begin
            old_sample = bypass_data_reg;
        end else begin
            old_sample = $signed(ram_rd_data);
        end
    end

    assign sum_upd = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
    // With cooking off the ring is untouched and its present average is shown.
    assign div_in  = cooking_reg ? sum_upd : sum_reg;

    htc_avg_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .sum_i (div_in),
        .avg_o (avg)
    );

    assign over_temp = $signed({avg[SAMPLE_W-1], avg}) > $signed({2'b00, over_limit_reg});
    assign diff      = $signed({3'b000, target_reg}) - $signed({{2{avg[SAMPLE_W-1]}}, avg});
    assign enter_ext = $signed({3'b000, enter_reg});
    assign leave_ext = $signed({3'b000, leave_reg});
    // Only used for a non-negative error; at or past the span the drive is full.
    assign level = (diff >= DIFF_W'(LEVEL_SPAN)) ? LEVEL_W'(LEVEL_MAX)
                                                 : LEVEL_LUT[diff[LEVEL_IDX_W-1:0]];

    always_comb begin
        sum_next     = sum_reg;
        mode_next    = mode_reg;
        error_next   = error_reg;
        triac_next   = triac_reg;
        preheat_next = preheat_reg;
        master_next  = master_reg;
        if (!cooking_reg) begin
            triac_next   = '0;
            preheat_next = 1'b0;
            master_next  = 1'b0;
        end else begin
            sum_next = sum_upd;
            if (over_temp) begin
                error_next   = 1'b1;
                triac_next   = '0;
                preheat_next = 1'b0;
                master_next  = 1'b0;
            end else begin
                master_next = 1'b1;
                if (diff < 0) begin
                    triac_next   = '0;
                    preheat_next = 1'b0;
                    mode_next    = 1'b0;
                end else if (diff > enter_ext && !mode_reg) begin
                    triac_next   = '0;
                    preheat_next = 1'b1;
                    mode_next    = 1'b1;
                end else if ((diff < leave_ext && mode_reg) ||
                             (diff < enter_ext && !mode_reg)) begin
                    triac_next   = level;
                    preheat_next = 1'b0;
                    mode_next    = 1'b0;
                end
                // Otherwise the error sits inside the hysteresis band and the
                // drive outputs keep their values.
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= TARGET_RST;
            over_limit_reg <= OVER_LIMIT_RST;
            enter_reg      <= ENTER_RST;
            leave_reg      <= LEAVE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TARGET:     target_reg     <= cfg_data;
                CFG_OVER_LIMIT: over_limit_reg <= cfg_data;
                CFG_ENTER:      enter_reg      <= cfg_data;
                CFG_LEAVE:      leave_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            wp_reg         <= '0;
            sum_reg        <= '0;
            ring_valid_reg <= '0;
            mode_reg       <= 1'b0;
            error_reg      <= 1'b0;
            triac_reg      <= '0;
            preheat_reg    <= 1'b0;
            master_reg     <= 1'b0;
            bypass_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                sum_reg     <= sum_next;
                mode_reg    <= mode_next;
                error_reg   <= error_next;
                triac_reg   <= triac_next;
                preheat_reg <= preheat_next;
                master_reg  <= master_next;
            end
            if (ring_wr) begin
                ring_valid_reg[wp_reg] <= 1'b1;
            end
            wp_reg     <= wp_next;
            bypass_reg <= ring_wr && (wp_reg == wp_next);
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg  <= s_raw_sample;
            cooking_reg <= s_cooking;
        end
        if (advance) begin
            avg_out_reg <= avg;
        end
        bypass_data_reg <= sample_reg;
    end

    assign m_valid               = out_valid_reg;
    assign m_triac_level         = triac_reg;
    assign m_preheat_on          = preheat_reg;
    assign m_master_on           = master_reg;
    assign m_average_temperature = avg_out_reg;
    assign m_over_temp_error     = error_reg;
    assign m_preheating          = mode_reg;

endmodule

FILE: design/htc_checker.sv
// Port-level checks for the heater temperature controller and the bind that
// attaches them to the top level. Depends on htc_pkg.

module htc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [htc_pkg::LEVEL_W-1:0]         m_triac_level,
    input logic                                m_preheat_on,
    input logic                                m_master_on,
    input logic signed [htc_pkg::SAMPLE_W-1:0] m_average_temperature,
    input logic                                m_over_temp_error,
    input logic                                m_preheating
);

    import htc_pkg::*;

    // A stalled result word holds in every field but the over-temperature flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_triac_level) &&
            $stable(m_preheat_on) && $stable(m_master_on) &&
            $stable(m_average_temperature) && $stable(m_preheating))
        else $error("result word changed while stalled");

    // The over-temperature flag is cleared only by reset.
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_over_temp_error |=> m_over_temp_error)
        else $error("over-temperature flag dropped");

    // With master off, no heater drive may be active.
    a_master_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_master_on |-> m_triac_level == '0 && !m_preheat_on)
        else $error("drive active with master off");

    // Preheat drive only in preheat mode and never together with the triac.
    a_preheat_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_preheat_on |-> m_preheating && m_triac_level == '0)
        else $error("preheat drive inconsistent");

    // Proportional drive only outside preheat mode, with master on.
    a_triac_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_triac_level != '0 |-> m_master_on && !m_preheating)
        else $error("triac drive inconsistent");

endmodule

bind heater_temperature_controller_top htc_checker u_htc_checker (.*);

FILE: test/tb_heater_temperature_controller_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for heater_temperature_controller_top: a directed table, then
// random control ticks checked against a behavioral predictor of the controller.
// Depends on htc_pkg and the controller RTL.

module tb_heater_temperature_controller_top;
    import htc_pkg::*;

    localparam int WINDOW     = WINDOW_LEN_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int REPORT_MAX = 10;
    localparam int N_ROWS     = 29;
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 110;
    localparam int HOLD_LONG  = 150;

    // One result word of the controller, in port order.
    typedef struct packed {
        logic [LEVEL_W-1:0]         triac;
        logic                       preheat_on;
        logic                       master_on;
        logic signed [SAMPLE_W-1:0] average;
        logic                       over_temp;
        logic                       preheating;
    } heat_result_t;

    // One row of the directed table: either a register write or a tick word,
    // with an expected result typed in only where it is obvious.
    typedef struct packed {
        logic                       is_write;
        cfg_index_t                 reg_sel;
        logic [CFG_W-1:0]           reg_value;
        logic signed [SAMPLE_W-1:0] raw;
        logic                       cook;
        logic                       typed;
        heat_result_t               want;
    } step_row_t;

    localparam heat_result_t ALL_OFF = '0;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_raw_sample = '0;
    logic                       s_cooking = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [LEVEL_W-1:0]         m_triac_level;
    logic                       m_preheat_on;
    logic                       m_master_on;
    logic signed [SAMPLE_W-1:0] m_average_temperature;
    logic                       m_over_temp_error;
    logic                       m_preheating;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_index_t                 cfg_index = CFG_TARGET;
    logic [CFG_W-1:0]           cfg_data = '0;

    heater_temperature_controller_top uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_raw_sample          (s_raw_sample),
        .s_cooking             (s_cooking),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_triac_level         (m_triac_level),
        .m_preheat_on          (m_preheat_on),
        .m_master_on           (m_master_on),
        .m_average_temperature (m_average_temperature),
        .m_over_temp_error     (m_over_temp_error),
        .m_preheating          (m_preheating),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    // Directed table. It starts from the reset settings (setpoint 0, trip limit
    // 6000, margins 70 and 50), walks through preheat entry, the hold bands on
    // both sides of the hysteresis, proportional drive with clamping, a negative
    // error, a cooking-off tick, the over-temperature trip and a drive after the
    // trip, then the register extremes with the sample extremes.
    step_row_t dir_rows [N_ROWS] = '{
        '{1'b0, CFG_TARGET,     15'd0,     16'sd0,     1'b0, 1'b1, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd0,     1'b1, 1'b1,
          '{8'd0, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0}},
        '{1'b1, CFG_TARGET,     15'd100,   16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd0,     1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd3000,  1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd500,   1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd3500,  1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd1000,  1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd500,   1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd1500,  1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd750,   1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd750,   1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd5000,  1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd32767, 1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_OVER_LIMIT, 15'd100,   16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd0,     1'b1, 1'b1,
          '{8'd0, 1'b0, 1'b0, 16'sd130, 1'b1, 1'b0}},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd6500,  1'b1, 1'b1,
          '{8'd0, 1'b1, 1'b1, 16'sd0, 1'b1, 1'b1}},
        '{1'b1, CFG_ENTER,      15'd0,     16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_LEAVE,      15'd32767, 16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_TARGET,     15'd32767, 16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_OVER_LIMIT, 15'd32767, 16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd32767, 1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd32768, 1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd32768, 1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_TARGET,     15'd0,     16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_ENTER,      15'd32767, 16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b1, CFG_LEAVE,      15'd0,     16'sd0,     1'b0, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,    -16'sd32768, 1'b1, 1'b0, ALL_OFF},
        '{1'b0, CFG_TARGET,     15'd0,     16'sd32767, 1'b1, 1'b0, ALL_OFF}
    };

    // Predictor copy of the controller state and settings, at reset values.
    int   tap_ring [WINDOW] = '{default: 0};
    int   tap_pos = 0;
    int   tap_sum = 0;
    bit   in_preheat = 1'b0;
    bit   trip_flag = 1'b0;
    int   hold_level = 0;
    bit   hold_preheat = 1'b0;
    bit   hold_master = 1'b0;
    int   setpoint = int'(TARGET_RST);
    int   trip_limit = int'(OVER_LIMIT_RST);
    int   enter_margin = int'(ENTER_RST);
    int   leave_margin = int'(LEAVE_RST);

    heat_result_t pending_results [$];
    int   n_fail = 0;
    int   cycle_count = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    int   rx_hold_cycles = 0;

    // The clock runs from time zero; the period is 10 ns.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // A run that never finishes is a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("** heater_temperature_controller_top: FAILED **");
            $finish;
        end
    end

    // Applies one register write to the predictor's settings.
    function automatic void apply_setting(cfg_index_t sel, logic [CFG_W-1:0] value);
        case (sel)
            CFG_TARGET:     setpoint = int'(value);
            CFG_OVER_LIMIT: trip_limit = int'(value);
            CFG_ENTER:      enter_margin = int'(value);
            CFG_LEAVE:      leave_margin = int'(value);
            default: ;
        endcase
    endfunction

    // One control tick of the predictor. The ring and the running sum move only
    // while cooking; the error against the setpoint then picks the drive branch.
    // When no branch fits, the previous drive levels are kept.
    function automatic heat_result_t advance_controller(logic signed [SAMPLE_W-1:0] raw,
                                                        logic cook);
        heat_result_t res;
        int           avg;
        longint       diff;
        longint       level;
        avg = tap_sum / WINDOW;
        if (!cook) begin
            hold_level = 0;
            hold_preheat = 1'b0;
            hold_master = 1'b0;
        end else begin
            tap_sum = tap_sum - tap_ring[tap_pos] + int'(raw);
            tap_ring[tap_pos] = int'(raw);
            tap_pos = (tap_pos == WINDOW - 1) ? 0 : tap_pos + 1;
            avg = tap_sum / WINDOW;
            diff = longint'(setpoint) - longint'(avg);
            if (avg > trip_limit) begin
                trip_flag = 1'b1;
                hold_level = 0;
                hold_preheat = 1'b0;
                hold_master = 1'b0;
            end else begin
                hold_master = 1'b1;
                if (diff < 0) begin
                    hold_preheat = 1'b0;
                    hold_level = 0;
                    in_preheat = 1'b0;
                end else if (diff > enter_margin && !in_preheat) begin
                    hold_preheat = 1'b1;
                    hold_level = 0;
                    in_preheat = 1'b1;
                end else if ((diff < leave_margin && in_preheat) ||
                             (diff < enter_margin && !in_preheat)) begin
                    level = (diff * LEVEL_MAX) / LEVEL_SPAN;
                    if (level > LEVEL_MAX) level = LEVEL_MAX;
                    hold_preheat = 1'b0;
                    hold_level = int'(level);
                    in_preheat = 1'b0;
                end
            end
        end
        res.triac = LEVEL_W'(hold_level);
        res.preheat_on = hold_preheat;
        res.master_on = hold_master;
        res.average = SAMPLE_W'(avg);
        res.over_temp = trip_flag;
        res.preheating = in_preheat;
        return res;
    endfunction

    // Offers one tick word, waits for it to be taken and queues what it should
    // produce. Called and returning at a falling edge. A typed expectation, when
    // given, replaces the predicted one, but the predictor still advances.
    task automatic send_tick(logic signed [SAMPLE_W-1:0] raw, logic cook,
                             bit typed, heat_result_t want);
        int           gap;
        heat_result_t predicted;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_sample <= raw;
        s_cooking <= cook;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_controller(raw, cook);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // Writes one register while the block is idle; cfg_valid drops again at
    // the falling edge after the write is taken.
    task automatic write_reg(cfg_index_t sel, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        apply_setting(sel, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering ticks and waits until every expected result has arrived.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Result side: a random stall before each word, or one long hold-off when
    // the stimulus asks for it, so that the block backs up into its input.
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 6) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Every accepted result word is compared field by field with the oldest
    // expectation.
    always @(posedge aclk) begin : result_check
        heat_result_t got;
        heat_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_triac_level, m_preheat_on, m_master_on, m_average_temperature,
                    m_over_temp_error, m_preheating};
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_MAX)
                    $display("unexpected result word at %0t: %p", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= REPORT_MAX) begin
                        $display("mismatch at %0t:", $realtime);
                        $display("  expected triac %0d preheat %0b master %0b avg %0d err %0b mode %0b",
                                 want.triac, want.preheat_on, want.master_on, want.average,
                                 want.over_temp, want.preheating);
                        $display("  actual   triac %0d preheat %0b master %0b avg %0d err %0b mode %0b",
                                 got.triac, got.preheat_on, got.master_on, got.average,
                                 got.over_temp, got.preheating);
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases each with its own
    // register settings.
    initial begin
        int                         ph;
        int                         k;
        int                         pick;
        int                         drift;
        int                         value;
        logic [CFG_W-1:0]           new_target;
        logic [CFG_W-1:0]           new_limit;
        logic [CFG_W-1:0]           new_enter;
        logic [CFG_W-1:0]           new_leave;
        logic signed [SAMPLE_W-1:0] raw;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                settle();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_value);
            end else begin
                send_tick(dir_rows[i].raw, dir_rows[i].cook, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            // Settings change only once the block has drained; this is also the
            // point where the sender waits for every outstanding result.
            settle();
            case (ph)
                0: begin
                    new_target = '0;
                    new_limit = '0;
                    new_enter = '0;
                    new_leave = '0;
                end
                1: begin
                    new_target = '1;
                    new_limit = '1;
                    new_enter = '1;
                    new_leave = '1;
                end
                default: begin
                    new_target = CFG_W'($urandom_range(0, 4000));
                    new_limit = ($urandom_range(0, 1) == 0) ? '1 :
                                CFG_W'(int'(new_target) + $urandom_range(0, 600));
                    new_enter = CFG_W'($urandom_range(0, 300));
                    new_leave = CFG_W'($urandom_range(0, int'(new_enter) + 60));
                end
            endcase
            write_reg(CFG_TARGET, new_target);
            write_reg(CFG_OVER_LIMIT, new_limit);
            write_reg(CFG_ENTER, new_enter);
            write_reg(CFG_LEAVE, new_leave);

            // Two phases run flat out on both sides. In the pressure phase the
            // sender keeps offering while the receiver holds off for a long
            // stretch, so the input register and the result register both fill.
            tx_idle = !(ph == 4 || ph == 7 || ph == 5);
            rx_idle = !(ph == 4 || ph == 7);
            if (ph == 5) rx_hold_cycles = HOLD_LONG;

            // Samples mostly follow a ramp that starts well below the setpoint
            // and climbs through it, so the average passes through preheat, the
            // hysteresis band, proportional drive and overshoot in turn.
            drift = -int'(new_enter) - 200 - int'($urandom_range(0, 300));
            for (k = 0; k < PHASE_LEN; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    raw = SAMPLE_W'($urandom_range(0, 65535));
                end else begin
                    value = int'(new_target) + drift + int'($urandom_range(0, 100)) - 50;
                    if (value > 32767) value = 32767;
                    if (value < -32768) value = -32768;
                    raw = SAMPLE_W'(value);
                    drift = drift + int'($urandom_range(0, 30)) - 12;
                    if (drift > 400) drift = -int'(new_enter) - 200 - int'($urandom_range(0, 200));
                end
                send_tick(raw, (pick >= 10), 1'b0, ALL_OFF);
            end
        end

        // Every word is in; wait for the last results, then a little longer so
        // that any surplus word would be seen.
        settle();
        repeat (10) @(negedge aclk);
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("** heater_temperature_controller_top: PASSED **");
        end else begin
            $display("** heater_temperature_controller_top: FAILED **");
        end
        $finish;
    end

endmodule
